// ----- rtl/core/akc_pkg.sv -----
package akc_pkg;

  // Fixed widths of the port fields
  localparam int unsigned KeyPortW = 64;
  localparam int unsigned IdentW   = 32;

  typedef enum logic {
    ActInsert = 1'b0,
    ActLookup = 1'b1
  } act_e;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StDone
  } state_e;

  // Control part of the search word that ripples down the cell row
  typedef struct packed {
    logic valid;
    logic found;
  } tok_ctl_t;

endpackage

// ----- rtl/core/akc_cell.sv -----
// One cache entry plus one stage of the search row.
module akc_cell #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  akc_pkg::tok_ctl_t            ctl_i,
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic [akc_pkg::IdentW-1:0]   ident_i,
  output akc_pkg::tok_ctl_t            ctl_o,
  output logic [KEY_BITS-1:0]          key_o,
  output logic [akc_pkg::IdentW-1:0]   ident_o,
  input  logic                         wr_i,
  input  logic [KEY_BITS-1:0]          wr_key_i,
  input  logic [akc_pkg::IdentW-1:0]   wr_ident_i
);

  logic [KEY_BITS-1:0]        entry_key_q;
  logic [akc_pkg::IdentW-1:0] entry_ident_q;
  akc_pkg::tok_ctl_t          ctl_d, ctl_q;
  logic [akc_pkg::IdentW-1:0] ident_d, ident_q;
  logic [KEY_BITS-1:0]        key_q;
  logic                       match;

  assign match = (entry_key_q == key_i);

  // First match wins: an earlier cell's identifier is kept
  always_comb begin
    ctl_d.valid = ctl_i.valid;
    ctl_d.found = ctl_i.found | match;
    ident_d     = ctl_i.found ? ident_i : (match ? entry_ident_q : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_key_q   <= '0;
      entry_ident_q <= '0;
      ctl_q         <= '0;
    end else begin
      ctl_q <= ctl_d;
      if (wr_i) begin
        entry_key_q   <= wr_key_i;
        entry_ident_q <= wr_ident_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_i;
    ident_q <= ident_d;
  end

  assign ctl_o   = ctl_q;
  assign key_o   = key_q;
  assign ident_o = ident_q;

endmodule

// ----- rtl/core/assoc_key_cache_fifo_core.sv -----
// Fully associative key-to-identifier cache with round-robin replacement.
// Each of the ENTRIES cells holds one key/identifier pair; a request word is
// injected at cell 0 and moves one cell per cycle, each cell comparing its
// key and carrying the first match forward. When the word leaves the last
// cell the result is known; an insert that missed then writes the cell at
// the replacement pointer in the same cycle and the pointer advances,
// wrapping at ENTRIES. A lookup miss returns key 0 (root) and identifier 0.
// After reset every entry holds key 0 / identifier 0, so the root key hits.
// Keys are taken modulo 2^KEY_BITS. One word is in flight at a time: the
// walk down the cell row sets the pace, and the next word is accepted only
// once the result has moved from the pending to the output register.
// The output register lets the next word be accepted while a result waits.
module assoc_key_cache_fifo_core #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                action_i,
  input  logic [akc_pkg::KeyPortW-1:0]        lookup_key_i,
  input  logic [akc_pkg::IdentW-1:0]          file_ident_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic [akc_pkg::KeyPortW-1:0]        result_key_o,
  output logic [akc_pkg::IdentW-1:0]          result_ident_o,
  output logic                                written_o
);

  localparam int unsigned PtrW = $clog2(ENTRIES);

  akc_pkg::state_e state_d, state_q;
  akc_pkg::act_e   act_q;
  logic [PtrW-1:0] ptr_d, ptr_q;

  // Cell row interconnect; index 0 is the injection point
  akc_pkg::tok_ctl_t          ctl_w   [ENTRIES+1];
  logic [KEY_BITS-1:0]        key_w   [ENTRIES+1];
  logic [akc_pkg::IdentW-1:0] ident_w [ENTRIES+1];
  logic [ENTRIES-1:0]         wr_sel;

  logic in_acc, tail_vld, wr_en, out_load;

  // Pending result between the row tail and the output register
  logic                       pend_hit_q;
  logic [KEY_BITS-1:0]        pend_key_q;
  logic [akc_pkg::IdentW-1:0] pend_ident_q;
  logic                       pend_written_q;
  logic                       out_valid_q;

  // Identifier to store is held in a register from acceptance until the write
  logic [akc_pkg::IdentW-1:0] ins_ident_q;
  logic [akc_pkg::IdentW-1:0] pend_ident_src;
  assign pend_ident_src = ins_ident_q;

  assign in_acc   = in_valid_i && in_ready_o;
  assign tail_vld = ctl_w[ENTRIES].valid;

  // Inject the new word at the head of the row
  always_comb begin
    ctl_w[0].valid = in_acc;
    ctl_w[0].found = 1'b0;
    key_w[0]       = lookup_key_i[KEY_BITS-1:0];
    ident_w[0]     = '0;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign wr_sel[i] = wr_en && (ptr_q == PtrW'(i));
    akc_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl_w[i]),
      .key_i      (key_w[i]),
      .ident_i    (ident_w[i]),
      .ctl_o      (ctl_w[i+1]),
      .key_o      (key_w[i+1]),
      .ident_o    (ident_w[i+1]),
      .wr_i       (wr_sel[i]),
      .wr_key_i   (key_w[ENTRIES]),
      .wr_ident_i (pend_ident_src)
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      akc_pkg::StIdle: if (in_acc)   state_d = akc_pkg::StWalk;
      akc_pkg::StWalk: if (tail_vld) state_d = akc_pkg::StDone;
      akc_pkg::StDone: if (out_load) state_d = akc_pkg::StIdle;
      default:                       state_d = akc_pkg::StIdle;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      akc_pkg::StIdle: in_ready_o = 1'b1;
      akc_pkg::StWalk: wr_en = tail_vld && (act_q == akc_pkg::ActInsert) &&
                               !ctl_w[ENTRIES].found;
      akc_pkg::StDone: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    ptr_d = ptr_q;
    if (wr_en) begin
      ptr_d = (ptr_q == PtrW'(ENTRIES - 1)) ? '0 : ptr_q + PtrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= akc_pkg::StIdle;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q       <= akc_pkg::act_e'(action_i);
      ins_ident_q <= file_ident_i;
    end
    if (state_q == akc_pkg::StWalk && tail_vld) begin
      pend_hit_q <= ctl_w[ENTRIES].found;
      if (act_q == akc_pkg::ActInsert) begin
        pend_key_q     <= key_w[ENTRIES];
        pend_ident_q   <= '0;
        pend_written_q <= !ctl_w[ENTRIES].found;
      end else begin
        pend_key_q     <= ctl_w[ENTRIES].found ? key_w[ENTRIES] : '0;
        pend_ident_q   <= ident_w[ENTRIES];
        pend_written_q <= 1'b0;
      end
    end
    if (out_load) begin
      hit_o          <= pend_hit_q;
      result_key_o   <= akc_pkg::KeyPortW'(pend_key_q);
      result_ident_o <= pend_ident_q;
      written_o      <= pend_written_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // Assertions
  a_tail_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_vld |-> state_q == akc_pkg::StWalk)
    else $error("search word left the row outside a walk");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(wr_sel))
    else $error("more than one cell written");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PtrW'(ENTRIES - 1))
    else $error("replacement pointer out of range");

  a_write_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && written_o |-> !hit_o)
    else $error("written reported on a hit");

  a_ptr_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en |=> $stable(ptr_q))
    else $error("pointer moved without a write");

endmodule

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CacheEntries = 16;
  localparam int unsigned CacheKeyBits = 64;
  localparam logic [akc_pkg::KeyPortW-1:0] KeyMask =
    {akc_pkg::KeyPortW{1'b1}} >> (akc_pkg::KeyPortW - CacheKeyBits);
  localparam int unsigned PoolSize = 24;      // more keys than entries, so eviction happens
  localparam int unsigned MaxPrinted = 40;    // cap on printed mismatch lines

  // One result word as the block presents it
  typedef struct packed {
    logic                         hit;
    logic [akc_pkg::KeyPortW-1:0] key;
    logic [akc_pkg::IdentW-1:0]   ident;
    logic                         written;
  } reply_t;

  // Shadow copy of the cache plus the queue of replies it predicts.
  class key_cache_shadow;
    logic [akc_pkg::KeyPortW-1:0] keys   [CacheEntries];
    logic [akc_pkg::IdentW-1:0]   idents [CacheEntries];
    int unsigned                  fill_ptr;
    reply_t                       pending [$];
    int unsigned                  mismatches;
    int unsigned                  inserts_written;
    int unsigned                  inserts_present;
    int unsigned                  lookup_hits;
    int unsigned                  lookup_misses;
    int unsigned                  replies_seen;

    function void clear();
      foreach (keys[i]) begin
        keys[i]   = '0;
        idents[i] = '0;
      end
      fill_ptr = 0;
      pending.delete();
    endfunction

    // Apply one accepted request word and queue the reply it must produce
    function void note_request(akc_pkg::act_e act, logic [akc_pkg::KeyPortW-1:0] key_in,
                               logic [akc_pkg::IdentW-1:0] ident_in);
      reply_t                       r;
      logic [akc_pkg::KeyPortW-1:0] key;
      int                           slot;
      key  = key_in & KeyMask;
      slot = -1;
      // lowest-numbered match wins
      for (int i = CacheEntries - 1; i >= 0; i--)
        if (keys[i] == key) slot = i;
      r = '0;
      if (act == akc_pkg::ActInsert) begin
        r.hit = (slot >= 0);
        r.key = key;
        if (slot < 0) begin
          keys[fill_ptr]   = key;
          idents[fill_ptr] = ident_in;
          fill_ptr         = (fill_ptr + 1) % CacheEntries;
          r.written        = 1'b1;
          inserts_written++;
        end else begin
          inserts_present++;
        end
      end else if (slot >= 0) begin
        r.hit   = 1'b1;
        r.key   = key;
        r.ident = idents[slot];
        lookup_hits++;
      end else begin
        lookup_misses++;   // miss reports root key 0, ident 0
      end
      pending.push_back(r);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= MaxPrinted) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_reply(reply_t got);
      reply_t want;
      replies_seen++;
      if (pending.size() == 0) begin
        report_mismatch("result word with no request outstanding");
        return;
      end
      want = pending.pop_front();
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit %0b, want %0b", got.hit, want.hit));
      if (got.key !== want.key)
        report_mismatch($sformatf("result_key %h, want %h", got.key, want.key));
      if (got.ident !== want.ident)
        report_mismatch($sformatf("result_ident %h, want %h", got.ident, want.ident));
      if (got.written !== want.written)
        report_mismatch($sformatf("written %0b, want %0b", got.written, want.written));
    endtask
  endclass

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid_i   = 1'b0;
  logic                         in_ready_o;
  logic                         action_i     = 1'b0;
  logic [akc_pkg::KeyPortW-1:0] lookup_key_i = '0;
  logic [akc_pkg::IdentW-1:0]   file_ident_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i  = 1'b0;
  logic                         hit_o;
  logic [akc_pkg::KeyPortW-1:0] result_key_o;
  logic [akc_pkg::IdentW-1:0]   result_ident_o;
  logic                         written_o;

  key_cache_shadow              shadow;
  logic [akc_pkg::KeyPortW-1:0] key_pool [PoolSize];
  int unsigned                  src_idle_pct   = 0;   // chance per cycle the sender stays idle
  int unsigned                  sink_stall_pct = 0;   // chance per cycle the receiver stalls
  logic                         rx_hold        = 1'b0; // long receiver hold-off in progress

  assoc_key_cache_fifo_core #(
    .ENTRIES (CacheEntries),
    .KEY_BITS(CacheKeyBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .lookup_key_i  (lookup_key_i),
    .file_ident_i  (file_ident_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .result_key_o  (result_key_o),
    .result_ident_o(result_ident_o),
    .written_o     (written_o)
  );

  always #10 clk_i = ~clk_i;

  // Receiver: random stalls, forced low during a hold-off
  always @(posedge clk_i) begin
    if (!rst_ni || rx_hold) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Result monitor; values sampled here are the ones the edge acts on
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      shadow.check_reply('{hit: hit_o, key: result_key_o, ident: result_ident_o,
                           written: written_o});
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10ms;
    $display("timeout: %0d result words still expected", shadow.pending.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Present one request word, hold it until taken, then maybe go idle
  task automatic send_word(akc_pkg::act_e act, logic [akc_pkg::KeyPortW-1:0] key,
                           logic [akc_pkg::IdentW-1:0] ident);
    in_valid_i   <= 1'b1;
    action_i     <= act;
    lookup_key_i <= key;
    file_ident_i <= ident;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.note_request(act, key, ident);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  // Mostly keys from a small pool so inserts and lookups collide; some root,
  // all-ones and fully random keys to toggle every key bit.
  task automatic send_random_word();
    int unsigned                  pick;
    logic [akc_pkg::KeyPortW-1:0] key;
    akc_pkg::act_e                act;
    pick = $urandom_range(99);
    if (pick < 70)      key = key_pool[$urandom_range(PoolSize - 1)];
    else if (pick < 78) key = '0;
    else if (pick < 82) key = '1;
    else                key = {$urandom, $urandom};
    act = ($urandom_range(1) == 1) ? akc_pkg::ActLookup : akc_pkg::ActInsert;
    send_word(act, key, $urandom);
  endtask

  task automatic run_phase(int unsigned n_words, int unsigned idle_pct, int unsigned stall_pct);
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (n_words) send_random_word();
  endtask

  // Receiver hold-off counted in its own process
  task automatic hold_receiver(int unsigned n_cycles);
    rx_hold <= 1'b1;
    repeat (n_cycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  endtask

  initial begin
    shadow = new();
    shadow.clear();
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i]      = {$urandom, $urandom};
      key_pool[i][7:0] = 8'(i + 1);   // distinct and never root
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: root present everywhere after reset
    send_word(akc_pkg::ActLookup, '0, '0);
    send_word(akc_pkg::ActInsert, '0, 32'h0000_1234);   // root already held: no write
    send_word(akc_pkg::ActLookup, '1, '0);              // miss
    send_word(akc_pkg::ActInsert, '1, '1);              // lands in entry 0
    send_word(akc_pkg::ActLookup, '1, 32'h5555_5555);   // hit, ident ignored on lookup
    send_word(akc_pkg::ActInsert, '1, '0);              // present key: pointer stays
    // fill the rest so the pointer wraps and every root entry is gone
    for (int i = 0; i < CacheEntries - 1; i++)
      send_word(akc_pkg::ActInsert, key_pool[i], {$urandom});
    send_word(akc_pkg::ActLookup, '0, '0);              // root now misses
    send_word(akc_pkg::ActInsert, '0, 32'hA5A5_A5A5);   // root written, evicts all-ones
    send_word(akc_pkg::ActLookup, '1, '0);              // evicted key misses
    send_word(akc_pkg::ActLookup, '0, '0);              // root hits with stored ident

    // Random traffic under several idle patterns
    run_phase(340, 0, 0);
    run_phase(300, 82, 0);
    run_phase(300, 0, 82);
    run_phase(300, 38, 38);

    // Back-pressure: receiver stops for a long stretch while words keep coming
    fork
      hold_receiver(400);
    join_none
    run_phase(60, 0, 0);

    in_valid_i <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk_i);
    repeat (CacheEntries + 4) @(posedge clk_i);

    if (shadow.pending.size() != 0)
      shadow.report_mismatch($sformatf("%0d result words never arrived",
                                       shadow.pending.size()));
    $display("Run: %0d result words checked; inserts wrote %0d, found present %0d;",
             shadow.replies_seen, shadow.inserts_written, shadow.inserts_present);
    $display("lookups hit %0d, missed %0d; idle/stall phases and a long output hold.",
             shadow.lookup_hits, shadow.lookup_misses);
    if (shadow.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/akc_pkg.sv
rtl/core/akc_cell.sv
rtl/core/assoc_key_cache_fifo_core.sv
tb/tb.sv
